FILE: rtl/core/u8dec_pkg.sv
// Package for the UTF-8 validating decoder: result status codes, result word type
// and byte-class constants. No dependencies.
package u8dec_pkg;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_MORE    = 2'd2
    } t_status;

    typedef struct packed {
        logic [20:0] code_point;
        t_status     status;
        logic [2:0]  consumed_count;
        logic        last_of_run;
    } t_result;

    localparam logic [7:0] LEAD_MIN  = 8'hC2;
    localparam logic [7:0] LEAD_MAX  = 8'hF4;
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;
    localparam logic [7:0] CONT_A0   = 8'hA0;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CONT_8F   = 8'h8F;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] CONT_BITS = 8'h3F;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] LEAD4_BITS = 8'h07;

endpackage

FILE: rtl/core/u8dec_core.sv
// Decode step of the UTF-8 validating decoder: sequence state registers and the
// per-byte logic that yields up to two results. Depends on u8dec_pkg.
module u8dec_core
    import u8dec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    input  logic        i_eoi,
    output logic [1:0]  o_num,
    output t_result     o_res0,
    output t_result     o_res1
);

    logic [1:0]  r_held,  n_held;
    logic [2:0]  r_exp,   n_exp;
    logic [7:0]  r_lead,  n_lead;
    logic [20:0] r_acc,   n_acc;

    logic        w_lead_emit;
    t_result     w_lead_res;
    logic        w_lead_hold;
    logic [2:0]  w_lead_exp;
    logic [20:0] w_lead_acc;
    logic        w_cont;
    logic        w_ok;
    logic [2:0]  w_next_cnt;
    logic [20:0] w_shift_acc;

    always_comb begin
        w_lead_emit = 1'b1;
        w_lead_hold = 1'b0;
        w_lead_res  = '0;
        w_lead_res.consumed_count = 3'd1;
        w_lead_res.last_of_run    = 1'b1;
        if (i_byte < LEAD_E0) begin
            w_lead_exp = 3'd2;
            w_lead_acc = {16'd0, i_byte[4:0] & LEAD2_BITS[4:0]};
        end else if (i_byte < LEAD_F0) begin
            w_lead_exp = 3'd3;
            w_lead_acc = {17'd0, i_byte[3:0] & LEAD3_BITS[3:0]};
        end else begin
            w_lead_exp = 3'd4;
            w_lead_acc = {18'd0, i_byte[2:0] & LEAD4_BITS[2:0]};
        end
        if (!i_byte[7]) begin
            w_lead_res.code_point = {13'd0, i_byte};
            w_lead_res.status     = ST_DONE;
        end else if (i_byte < LEAD_MIN || i_byte > LEAD_MAX) begin
            w_lead_res.status = ST_INVALID;
        end else if (i_eoi) begin
            w_lead_res.status = ST_MORE;
        end else begin
            w_lead_emit = 1'b0;
            w_lead_hold = 1'b1;
        end
    end

    always_comb begin
        w_cont = (i_byte & CONT_MASK) == CONT_TAG;
        w_ok   = w_cont;
        if (r_held == 2'd1) begin
            if (r_lead == LEAD_E0 && i_byte < CONT_A0) w_ok = 1'b0;
            if (r_lead == LEAD_ED && i_byte >= CONT_A0) w_ok = 1'b0;
            if (r_lead == LEAD_F0 && i_byte < CONT_90) w_ok = 1'b0;
            if (r_lead == LEAD_F4 && i_byte > CONT_8F) w_ok = 1'b0;
        end
        w_next_cnt  = {1'b0, r_held} + 3'd1;
        w_shift_acc = {r_acc[14:0], i_byte[5:0] & CONT_BITS[5:0]};
    end

    always_comb begin
        n_held = r_held;
        n_exp  = r_exp;
        n_lead = r_lead;
        n_acc  = r_acc;
        o_num  = 2'd0;
        o_res0 = '0;
        o_res1 = '0;
        if (i_fire) begin
            if (r_held == 2'd0 || !w_ok) begin
                if (w_lead_hold) begin
                    n_held = 2'd1;
                    n_exp  = w_lead_exp;
                    n_lead = i_byte;
                    n_acc  = w_lead_acc;
                end else begin
                    n_held = '0;
                    n_exp  = '0;
                    n_lead = '0;
                    n_acc  = '0;
                end
                if (r_held == 2'd0) begin
                    o_num  = {1'b0, w_lead_emit};
                    o_res0 = w_lead_res;
                end else begin
                    o_res0.status         = ST_INVALID;
                    o_res0.consumed_count = {1'b0, r_held};
                    o_res0.last_of_run    = !w_lead_emit;
                    o_res1                = w_lead_res;
                    o_num                 = w_lead_emit ? 2'd2 : 2'd1;
                end
            end else if (w_next_cnt >= r_exp || i_eoi) begin
                n_held = '0;
                n_exp  = '0;
                n_lead = '0;
                n_acc  = '0;
                o_num  = 2'd1;
                o_res0.consumed_count = w_next_cnt;
                o_res0.last_of_run    = 1'b1;
                if (w_next_cnt >= r_exp) begin
                    o_res0.code_point = w_shift_acc;
                    o_res0.status     = ST_DONE;
                end else begin
                    o_res0.status = ST_MORE;
                end
            end else begin
                n_held = w_next_cnt[1:0];
                n_acc  = w_shift_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_exp  <= '0;
            r_lead <= '0;
            r_acc  <= '0;
        end else begin
            r_held <= n_held;
            r_exp  <= n_exp;
            r_lead <= n_lead;
            r_acc  <= n_acc;
        end
    end

    a_clear_after_eoi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eoi) |=> (r_held == 2'd0))
        else $error("sequence state held after end-of-input byte");

    a_two_needs_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_num == 2'd2) |-> (o_res0.status == ST_INVALID && !o_res0.last_of_run))
        else $error("second result without invalid prefix");

endmodule

FILE: rtl/core/u8dec_fifo.sv
// Four-entry result queue of the UTF-8 validating decoder; takes zero, one or
// two results per cycle and releases one per word. Depends on u8dec_pkg.
module u8dec_fifo
    import u8dec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_num,
    input  t_result    i_res0,
    input  t_result    i_res1,
    input  logic       i_pop,
    output logic       o_room,
    output logic       o_valid,
    output t_result    o_head
);

    t_result    r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_cnt, n_cnt;
    logic       w_pop;

    assign w_pop   = i_pop && (r_cnt != 3'd0);
    assign o_valid = r_cnt != 3'd0;
    assign o_head  = r_mem[r_rd];
    assign o_room  = r_cnt <= 3'd2;

    always_comb begin
        n_wr  = r_wr + i_num;
        n_rd  = r_rd + {1'b0, w_pop};
        n_cnt = r_cnt + {1'b0, i_num} - {2'd0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_num != 2'd0) r_mem[r_wr] <= i_res0;
        if (i_num == 2'd2) r_mem[r_wr + 2'd1] <= i_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_num != 2'd0) |-> (r_cnt <= 3'd2))
        else $error("result queue overflow");

endmodule

FILE: rtl/core/utf8_validating_decoder_top.sv
// UTF-8 validating decoder top level: input register, decode step and result queue.
// An accepted byte passes through the input register and then the result queue before its results reach the output.
// Throughput: one byte per cycle while the result queue has room and each byte yields at most
// one result; a byte that yields an invalid prefix plus a new result takes one extra output word.
// Reset (i_rst_n low, synchronous) clears the sequence state, input register and queue.
module utf8_validating_decoder_top
    import u8dec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // end_of_input
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [20:0] code_point, [22:21] status,
                                          // [25:23] consumed_count, [31:26] zero
    output logic        o_m_axis_tlast    // last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    logic       w_room;
    logic       w_fire;
    logic [1:0] w_num;
    t_result    w_res0;
    t_result    w_res1;
    t_result    w_head;

    assign w_fire          = r_in_valid && w_room;
    assign o_s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eoi  <= i_s_axis_tlast;
        end
    end

    u8dec_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .o_num   (w_num),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    u8dec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (w_num),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .i_pop   (i_m_axis_tready),
        .o_room  (w_room),
        .o_valid (o_m_axis_tvalid),
        .o_head  (w_head)
    );

    assign o_m_axis_tdata = {6'd0, w_head.consumed_count, w_head.status, w_head.code_point};
    assign o_m_axis_tlast = w_head.last_of_run;

    a_cp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_head.status != ST_DONE) |-> (w_head.code_point == 21'd0))
        else $error("nonzero code point on a failed result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_head.consumed_count != 3'd0 && w_head.consumed_count <= 3'd4))
        else $error("consumed count out of range");

endmodule
